[src/ubx_pkg.sv]
// package: item types, sync bytes, status and operation codes for the ubx deframer
`timescale 1ns / 1ps
package ubx_pkg;

  localparam int SIZE_W = 17;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;
  localparam logic [SIZE_W-1:0] HEAD_BYTES = 17'd6;
  localparam logic [SIZE_W-1:0] SUM_BYTES  = 17'd2;
  localparam logic [SIZE_W-1:0] MIN_FRAME  = HEAD_BYTES + SUM_BYTES;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_EOS   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam logic [2:0] ST_MORE  = 3'd0;
  localparam logic [2:0] ST_SKIP  = 3'd1;
  localparam logic [2:0] ST_OVER  = 3'd2;
  localparam logic [2:0] ST_OK    = 3'd3;
  localparam logic [2:0] ST_BAD   = 3'd4;
  localparam logic [2:0] ST_TRUNC = 3'd5;
  localparam logic [2:0] ST_NONE  = 3'd6;
  localparam logic [2:0] ST_READ  = 3'd7;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  data_byte;
    logic [63:0] stamp_ns;
    logic        stamp_present;
    logic [9:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  class_byte;
    logic [7:0]  message_byte;
    logic [9:0]  payload_length;
    logic [9:0]  frame_start;
    logic [7:0]  sent_sum_a;
    logic [7:0]  sent_sum_b;
    logic [7:0]  calc_sum_a;
    logic [7:0]  calc_sum_b;
    logic [63:0] frame_stamp_ns;
    logic        frame_stamp_present;
    logic [7:0]  read_data;
  } out_item_t;

endpackage

[src/ubx_frame_deframer_unit.sv]
// ubx frame deframer: sync hunt, byte and stamp stores, checksum check and recovery scan
// push, end of stream, spare: registered the cycle after the item, unless a scan starts
// read item: the byte store read is registered, then S_RDOP registers the result
// bad checksum: store walked again, headers read per offset, checksum summed per candidate
// throughput: one item per cycle, except during reads, the recovery scan and output stalls
// reset: synchronous active low, clears fill count, size and start stamp, limit back to 1024
`timescale 1ns / 1ps
module ubx_frame_deframer_unit #(
  parameter int STORE_DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ubx_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ubx_pkg::out_item_t out_data,
  input  logic              cfg_wr_en,
  input  logic [10:0]       cfg_wr_data
);
  import ubx_pkg::*;

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam logic [SIZE_W-1:0] DEPTH_S = SIZE_W'(STORE_DEPTH);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RDOP = 8'b0000_0010,
    S_HDR0 = 8'b0000_0100,
    S_HDR1 = 8'b0000_1000,
    S_HDR2 = 8'b0001_0000,
    S_HDR3 = 8'b0010_0000,
    S_HDR4 = 8'b0100_0000,
    S_SUM  = 8'b1000_0000
  } state_t;

  logic [7:0]  byte_mem  [STORE_DEPTH];
  logic [64:0] stamp_mem [STORE_DEPTH];

  state_t state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [SIZE_W-1:0] exp_r, exp_nxt;
  logic [64:0] start_r, start_nxt;
  logic [10:0] max_r;
  logic [7:0] sum_a_r, sum_a_nxt, sum_b_r, sum_b_nxt;
  logic [7:0] d1_r, d1_nxt, d2_r, d2_nxt;
  logic [7:0] cls_r, cls_nxt, id_r, id_nxt, lo_r, lo_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;
  logic rd_oob_r, rd_oob_nxt;

  // recovery scan
  logic [CW-1:0] off_r, off_nxt, sz_r, sz_nxt, jis_r, jis_nxt, jd_r, jd_nxt;
  logic [AW-1:0] ra_r, ra_nxt;
  logic dv_r, dv_nxt;
  logic [7:0] ca_r, ca_nxt, cb_r, cb_nxt, cd1_r, cd1_nxt, cd2_r, cd2_nxt;
  logic [7:0] ccls_r, ccls_nxt, cid_r, cid_nxt, clo_r, clo_nxt;
  logic [64:0] cst_r, cst_nxt;

  logic [AW-1:0] rd_addr;
  logic [7:0] byte_rd_r;
  logic [64:0] stamp_rd_r;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  logic [64:0] wr_stamp;

  logic in_acc;
  logic [SIZE_W-1:0] lim, off_s, fill_s, adv_s, sz_s, exp_new, nf_s;
  logic [CW-1:0] nf;
  logic [7:0] fa, fb, pa, pb;
  out_item_t zero_item;

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign zero_item = '0;

  assign lim    = (SIZE_W'(max_r) < DEPTH_S) ? SIZE_W'(max_r) : DEPTH_S;
  assign off_s  = SIZE_W'(off_r);
  assign fill_s = SIZE_W'(fill_r);
  assign adv_s  = off_s + SIZE_W'(1);
  assign sz_s   = MIN_FRAME + SIZE_W'({byte_rd_r, clo_r});
  assign exp_new = MIN_FRAME + SIZE_W'({in_data.data_byte, lo_r});
  assign nf     = fill_r + CW'(1);
  assign nf_s   = SIZE_W'(nf);
  assign wr_stamp = {in_data.stamp_present,
                     in_data.stamp_present ? in_data.stamp_ns : 64'd0};

  // primary and candidate running sums, folding the byte two places back
  assign pa = sum_a_r + d2_r;
  assign pb = sum_b_r + pa;
  assign fa = ca_r + cd2_r;
  assign fb = cb_r + fa;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      byte_mem[wr_addr]  <= in_data.data_byte;
      stamp_mem[wr_addr] <= wr_stamp;
    end
  end

  always_ff @(posedge clk) begin
    byte_rd_r  <= byte_mem[rd_addr];
    stamp_rd_r <= stamp_mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    fill_nxt = fill_r;
    exp_nxt = exp_r;
    start_nxt = start_r;
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    d1_nxt = d1_r;
    d2_nxt = d2_r;
    cls_nxt = cls_r;
    id_nxt = id_r;
    lo_nxt = lo_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt = out_r;
    rd_oob_nxt = rd_oob_r;
    off_nxt = off_r;
    sz_nxt = sz_r;
    jis_nxt = jis_r;
    jd_nxt = jd_r;
    ra_nxt = ra_r;
    dv_nxt = 1'b0;
    ca_nxt = ca_r;
    cb_nxt = cb_r;
    cd1_nxt = cd1_r;
    cd2_nxt = cd2_r;
    ccls_nxt = ccls_r;
    cid_nxt = cid_r;
    clo_nxt = clo_r;
    cst_nxt = cst_r;
    rd_addr = AW'(in_data.read_index);
    wr_en = 1'b0;
    wr_addr = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          out_nxt = zero_item;
          out_valid_nxt = 1'b1;
          case (in_data.operation)
            OP_PUSH: begin
              if (fill_r == '0) begin
                if (in_data.data_byte != SYNC_FIRST) begin
                  out_nxt.status = ST_SKIP;
                end else begin
                  wr_en = 1'b1;
                  fill_nxt = CW'(1);
                  start_nxt = wr_stamp;
                  exp_nxt = '0;
                  out_nxt.status = ST_MORE;
                end
              end else if (fill_r == CW'(1)) begin
                if (in_data.data_byte == SYNC_SECOND) begin
                  wr_en = 1'b1;
                  wr_addr = AW'(1);
                  fill_nxt = CW'(2);
                  out_nxt.status = ST_MORE;
                end else if (in_data.data_byte == SYNC_FIRST) begin
                  wr_en = 1'b1;
                  start_nxt = wr_stamp;
                  out_nxt.status = ST_MORE;
                end else begin
                  fill_nxt = '0;
                  exp_nxt = '0;
                  start_nxt = '0;
                  out_nxt.status = ST_SKIP;
                end
              end else if (fill_s >= DEPTH_S) begin
                fill_nxt = '0;
                exp_nxt = '0;
                start_nxt = '0;
                out_nxt.status = ST_OVER;
              end else begin
                wr_en = 1'b1;
                wr_addr = AW'(fill_r);
                fill_nxt = nf;
                d1_nxt = in_data.data_byte;
                d2_nxt = d1_r;
                if (fill_r == CW'(2)) begin
                  cls_nxt = in_data.data_byte;
                  sum_a_nxt = '0;
                  sum_b_nxt = '0;
                end
                if (fill_r == CW'(3)) id_nxt = in_data.data_byte;
                if (fill_r == CW'(4)) lo_nxt = in_data.data_byte;
                if (fill_r >= CW'(4)) begin
                  sum_a_nxt = pa;
                  sum_b_nxt = pb;
                end
                if (nf_s == HEAD_BYTES) exp_nxt = exp_new;
                if (((nf_s == HEAD_BYTES) && (exp_new > lim)) || (nf_s > lim)) begin
                  fill_nxt = '0;
                  exp_nxt = '0;
                  start_nxt = '0;
                  out_nxt.status = ST_OVER;
                end else if ((exp_nxt == '0) || (nf_s < exp_nxt)) begin
                  out_nxt.status = ST_MORE;
                end else begin
                  out_nxt.class_byte = cls_r;
                  out_nxt.message_byte = id_r;
                  out_nxt.payload_length = 10'(exp_r - MIN_FRAME);
                  out_nxt.sent_sum_a = d1_r;
                  out_nxt.sent_sum_b = in_data.data_byte;
                  out_nxt.calc_sum_a = pa;
                  out_nxt.calc_sum_b = pb;
                  out_nxt.frame_stamp_ns = start_r[63:0];
                  out_nxt.frame_stamp_present = start_r[64];
                  if ((d1_r == pa) && (in_data.data_byte == pb)) begin
                    out_nxt.status = ST_OK;
                    fill_nxt = '0;
                    exp_nxt = '0;
                    start_nxt = '0;
                  end else begin
                    // keep the bad report parked while later offsets are tried
                    out_nxt.status = ST_BAD;
                    off_nxt = CW'(1);
                    if (SIZE_W'(1) + MIN_FRAME > nf_s) begin
                      fill_nxt = '0;
                      exp_nxt = '0;
                      start_nxt = '0;
                    end else begin
                      out_valid_nxt = 1'b0;
                      state_nxt = S_HDR0;
                    end
                  end
                end
              end
            end
            OP_EOS: begin
              if (fill_r == '0) begin
                out_nxt.status = ST_NONE;
              end else begin
                fill_nxt = '0;
                exp_nxt = '0;
                start_nxt = '0;
                out_nxt.status = ST_TRUNC;
              end
            end
            OP_READ: begin
              out_valid_nxt = 1'b0;
              rd_oob_nxt = !(SIZE_W'(in_data.read_index) < DEPTH_S);
              state_nxt = S_RDOP;
            end
            default: begin
              out_nxt.status = ST_NONE;
            end
          endcase
        end
      end
      S_RDOP: begin
        out_nxt = zero_item;
        out_nxt.status = ST_READ;
        out_nxt.read_data = rd_oob_r ? 8'd0 : byte_rd_r;
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_HDR0: begin
        rd_addr = AW'(off_r);
        state_nxt = S_HDR1;
      end
      S_HDR1: begin
        cst_nxt = stamp_rd_r;
        rd_addr = AW'(off_s + SIZE_W'(1));
        state_nxt = (byte_rd_r == SYNC_FIRST) ? S_HDR2 : S_IDLE;
      end
      S_HDR2: begin
        rd_addr = AW'(off_s + SIZE_W'(4));
        state_nxt = (byte_rd_r == SYNC_SECOND) ? S_HDR3 : S_IDLE;
      end
      S_HDR3: begin
        clo_nxt = byte_rd_r;
        rd_addr = AW'(off_s + SIZE_W'(5));
        state_nxt = S_HDR4;
      end
      S_HDR4: begin
        if ((sz_s > lim) || (sz_s > fill_s - off_s)) begin
          state_nxt = S_IDLE;
        end else begin
          sz_nxt = CW'(sz_s);
          ca_nxt = '0;
          cb_nxt = '0;
          ra_nxt = AW'(off_s + SIZE_W'(2));
          jis_nxt = CW'(2);
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        if (jis_r < sz_r) begin
          rd_addr = ra_r;
          ra_nxt = ra_r + AW'(1);
          jis_nxt = jis_r + CW'(1);
          dv_nxt = 1'b1;
          jd_nxt = jis_r;
        end
        if (dv_r) begin
          cd1_nxt = byte_rd_r;
          cd2_nxt = cd1_r;
          if (jd_r == CW'(2)) ccls_nxt = byte_rd_r;
          if (jd_r == CW'(3)) cid_nxt = byte_rd_r;
          if (jd_r >= CW'(4)) begin
            ca_nxt = fa;
            cb_nxt = fb;
          end
          if (jd_r == sz_r - CW'(1)) begin
            dv_nxt = 1'b0;
            if ((cd1_r == fa) && (byte_rd_r == fb)) begin
              out_nxt = zero_item;
              out_nxt.status = ST_OK;
              out_nxt.class_byte = ccls_r;
              out_nxt.message_byte = cid_r;
              out_nxt.payload_length = 10'(SIZE_W'(sz_r) - MIN_FRAME);
              out_nxt.frame_start = 10'(off_r);
              out_nxt.sent_sum_a = cd1_r;
              out_nxt.sent_sum_b = byte_rd_r;
              out_nxt.calc_sum_a = fa;
              out_nxt.calc_sum_b = fb;
              out_nxt.frame_stamp_ns = cst_r[63:0];
              out_nxt.frame_stamp_present = cst_r[64];
              out_valid_nxt = 1'b1;
              fill_nxt = '0;
              exp_nxt = '0;
              start_nxt = '0;
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // a scan state that gives up lands on idle: next offset, or the parked bad report
    if ((state_r != S_IDLE) && (state_r != S_RDOP) && (state_nxt == S_IDLE) &&
        !out_valid_nxt) begin
      off_nxt = CW'(adv_s);
      if (adv_s + MIN_FRAME > fill_s) begin
        out_valid_nxt = 1'b1;
        fill_nxt = '0;
        exp_nxt = '0;
        start_nxt = '0;
      end else begin
        state_nxt = S_HDR0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r <= '0;
      exp_r <= '0;
      start_r <= '0;
      max_r <= 11'd1024;
      out_valid_r <= 1'b0;
      dv_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r <= fill_nxt;
      exp_r <= exp_nxt;
      start_r <= start_nxt;
      if (cfg_wr_en) max_r <= cfg_wr_data;
      out_valid_r <= out_valid_nxt;
      dv_r <= dv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_a_r <= sum_a_nxt;
    sum_b_r <= sum_b_nxt;
    d1_r <= d1_nxt;
    d2_r <= d2_nxt;
    cls_r <= cls_nxt;
    id_r <= id_nxt;
    lo_r <= lo_nxt;
    out_r <= out_nxt;
    rd_oob_r <= rd_oob_nxt;
    off_r <= off_nxt;
    sz_r <= sz_nxt;
    jis_r <= jis_nxt;
    jd_r <= jd_nxt;
    ra_r <= ra_nxt;
    ca_r <= ca_nxt;
    cb_r <= cb_nxt;
    cd1_r <= cd1_nxt;
    cd2_r <= cd2_nxt;
    ccls_r <= ccls_nxt;
    cid_r <= cid_nxt;
    clo_r <= clo_nxt;
    cst_r <= cst_nxt;
  end

endmodule

[bench/testbench.sv]
// testbench for the ubx frame deframer: frame predictor, stall driver and result checker
`timescale 1ns / 1ps
module testbench;
  import ubx_pkg::*;

  localparam int DEPTH = 1024;
  localparam int WATCHDOG_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [10:0] cfg_wr_data = '0;

  always #1 clk = ~clk;

  ubx_frame_deframer_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // predictor state
  logic [7:0] mirror_bytes [DEPTH];
  logic [63:0] mirror_stamps [DEPTH];
  logic mirror_has [DEPTH];
  int unsigned fill_cnt;
  int unsigned expect_len;
  logic [63:0] first_stamp;
  logic first_has;
  int unsigned frame_limit;
  // pushes fill the store from entry 0 upward, so the written entries form a prefix
  int unsigned stored_top = 0;

  in_item_t pending_items[$];
  out_item_t expected_results[$];
  int mismatch_count = 0;
  bit quiet_tail = 1'b0;
  bit feeding = 1'b0;

  function automatic int unsigned stored(int unsigned i);
    return (i < DEPTH) ? mirror_bytes[i] : 0;
  endfunction

  function automatic bit build_frame(int unsigned off, int unsigned sz, logic [63:0] sv,
                                     logic sp, inout out_item_t r);
    int unsigned a;
    int unsigned b;
    a = 0;
    b = 0;
    for (int unsigned i = off + 2; i < off + sz - 2; i++) begin
      a = (a + stored(i)) & 8'hFF;
      b = (b + a) & 8'hFF;
    end
    r.class_byte = 8'(stored(off + 2));
    r.message_byte = 8'(stored(off + 3));
    r.payload_length = 10'(sz - 8);
    r.frame_start = 10'(off);
    r.sent_sum_a = 8'(stored(off + sz - 2));
    r.sent_sum_b = 8'(stored(off + sz - 1));
    r.calc_sum_a = 8'(a);
    r.calc_sum_b = 8'(b);
    r.frame_stamp_ns = sp ? sv : 64'd0;
    r.frame_stamp_present = sp;
    return r.sent_sum_a == a && r.sent_sum_b == b;
  endfunction

  function automatic void drop_frame();
    fill_cnt = 0;
    expect_len = 0;
    first_stamp = '0;
    first_has = 1'b0;
  endfunction

  function automatic void store_byte(int unsigned i, in_item_t it);
    if (i < DEPTH) begin
      mirror_bytes[i] = it.data_byte;
      mirror_stamps[i] = it.stamp_present ? it.stamp_ns : 64'd0;
      mirror_has[i] = it.stamp_present;
      if (i + 1 > stored_top) stored_top = i + 1;
    end
  endfunction

  function automatic out_item_t deframe_push(in_item_t it);
    out_item_t r;
    out_item_t cand;
    int unsigned lim;
    int unsigned sz;
    r = '0;
    lim = (frame_limit < DEPTH) ? frame_limit : DEPTH;
    if (fill_cnt == 0) begin
      if (it.data_byte != SYNC_FIRST) begin
        r.status = ST_SKIP;
        return r;
      end
      store_byte(0, it);
      fill_cnt = 1;
      first_stamp = it.stamp_present ? it.stamp_ns : 64'd0;
      first_has = it.stamp_present;
      expect_len = 0;
      r.status = ST_MORE;
      return r;
    end
    if (fill_cnt == 1) begin
      if (it.data_byte == SYNC_SECOND) begin
        store_byte(1, it);
        fill_cnt = 2;
        r.status = ST_MORE;
      end else if (it.data_byte == SYNC_FIRST) begin
        store_byte(0, it);
        first_stamp = it.stamp_present ? it.stamp_ns : 64'd0;
        first_has = it.stamp_present;
        r.status = ST_MORE;
      end else begin
        drop_frame();
        r.status = ST_SKIP;
      end
      return r;
    end
    if (fill_cnt >= DEPTH) begin
      drop_frame();
      r.status = ST_OVER;
      return r;
    end
    store_byte(fill_cnt, it);
    fill_cnt++;
    if (fill_cnt == 6) begin
      expect_len = 8 + (stored(4) | (stored(5) << 8));
      if (expect_len > lim) begin
        drop_frame();
        r.status = ST_OVER;
        return r;
      end
    end
    if (fill_cnt > lim) begin
      drop_frame();
      r.status = ST_OVER;
      return r;
    end
    if (expect_len == 0 || fill_cnt < expect_len) begin
      r.status = ST_MORE;
      return r;
    end
    if (build_frame(0, fill_cnt, first_stamp, first_has, r)) begin
      r.status = ST_OK;
      drop_frame();
      return r;
    end
    // bad checksum: look for an embedded frame further in
    for (int unsigned off = 1; off + 8 <= fill_cnt; off++) begin
      if (stored(off) != SYNC_FIRST || stored(off + 1) != SYNC_SECOND) continue;
      sz = 8 + (stored(off + 4) | (stored(off + 5) << 8));
      if (sz > lim || sz > fill_cnt - off) continue;
      cand = '0;
      if (build_frame(off, sz, mirror_stamps[off], mirror_has[off], cand)) begin
        cand.status = ST_OK;
        drop_frame();
        return cand;
      end
    end
    r.status = ST_BAD;
    drop_frame();
    return r;
  endfunction

  function automatic out_item_t deframe_item(in_item_t it);
    out_item_t r;
    r = '0;
    case (it.operation)
      OP_PUSH: r = deframe_push(it);
      OP_EOS: begin
        if (fill_cnt == 0) begin
          r.status = ST_NONE;
        end else begin
          drop_frame();
          r.status = ST_TRUNC;
        end
      end
      OP_READ: begin
        r.status = ST_READ;
        r.read_data = 8'(stored(it.read_index));
      end
      default: r.status = ST_NONE;
    endcase
    return r;
  endfunction

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    in_item_t next_item;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_results = {expected_results, deframe_item(in_data)};
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (feeding && pending_items.size() > 0) begin
          next_item = pending_items.pop_front();
          // once some push has filled an entry, reads only go to entries that pushes have filled
          if (next_item.operation == OP_READ && stored_top > 0 &&
              next_item.read_index >= stored_top)
            next_item.read_index = 10'(next_item.read_index % stored_top);
          in_data <= next_item;
          in_valid <= 1'b1;
          if (!quiet_tail && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 19);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int out_gap = 0;
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result %p", out_data);
        end else begin
          want = expected_results.pop_front();
          if (out_data !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("mismatch: expected %p actual %p", want, out_data);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet_tail && $urandom_range(0, 9) == 0) out_gap <= $urandom_range(1, 19);
      end
    end
  end

  // watchdog
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  int unsigned written_max = 0;

  function automatic in_item_t push_of(logic [7:0] b);
    in_item_t it;
    it = '0;
    it.operation = OP_PUSH;
    it.data_byte = b;
    it.stamp_present = 1'($urandom_range(0, 1));
    it.stamp_ns = {$urandom, $urandom};
    return it;
  endfunction

  function automatic void queue_op(logic [1:0] op, logic [9:0] idx);
    in_item_t it;
    it = push_of(8'($urandom));
    it.operation = op;
    it.read_index = idx;
    pending_items = {pending_items, it};
  endfunction

  // queue a frame; corrupt spoils the checksum, embed hides a good frame inside a payload of 8 bytes or more
  function automatic void queue_frame(int unsigned plen, bit corrupt, bit embed);
    logic [7:0] fr[$];
    logic [7:0] a;
    logic [7:0] b;
    int unsigned ilen;
    fr = {SYNC_FIRST, SYNC_SECOND, 8'($urandom), 8'($urandom), 8'(plen), 8'(plen >> 8)};
    if (embed && plen >= 8) begin
      ilen = $urandom_range(0, plen - 8);
      fr = {fr, 8'($urandom)};
      fr = {fr, 8'($urandom)};
      for (int i = 0; i < 4 + ilen; i++) fr = {fr, 8'($urandom)};
      fr[6] = SYNC_FIRST;
      fr[7] = SYNC_SECOND;
      fr[10] = 8'(ilen);
      fr[11] = 8'(ilen >> 8);
      a = '0;
      b = '0;
      for (int i = 8; i < 12 + ilen; i++) begin
        a += fr[i];
        b += a;
      end
      fr = {fr, a};
      fr = {fr, b};
      while (fr.size() < 6 + plen) fr = {fr, 8'($urandom)};
    end else begin
      for (int i = 0; i < plen; i++) fr = {fr, 8'($urandom)};
    end
    a = '0;
    b = '0;
    for (int i = 2; i < fr.size(); i++) begin
      a += fr[i];
      b += a;
    end
    if (corrupt) a = a ^ 8'(1 << $urandom_range(0, 7));
    fr = {fr, a};
    fr = {fr, b};
    foreach (fr[i]) pending_items = {pending_items, push_of(fr[i])};
    written_max = (fr.size() > written_max) ? fr.size() : written_max;
  endfunction

  task automatic run_phase();
    feeding = 1'b1;
    wait (pending_items.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    feeding = 1'b0;
    repeat (2100) @(posedge clk);
  endtask

  task automatic set_limit(int unsigned v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v[10:0];
    frame_limit = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  int unsigned r;
  int unsigned limits[4] = '{1024, 8, 40, 2047};

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      mirror_bytes[i] = '0;
      mirror_stamps[i] = '0;
      mirror_has[i] = 1'b0;
    end
    drop_frame();
    frame_limit = 1024;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: specials, extremes, every operation
    queue_op(OP_EOS, 10'd0);
    queue_op(OP_SPARE, 10'h3FF);
    pending_items = {pending_items, push_of(8'h00)};
    pending_items = {pending_items, push_of(SYNC_FIRST)};
    pending_items = {pending_items, push_of(SYNC_FIRST)};
    pending_items = {pending_items, push_of(8'hFF)};
    pending_items = {pending_items, push_of(SYNC_FIRST)};
    queue_op(OP_EOS, 10'd0);
    queue_frame(0, 1'b0, 1'b0);
    queue_frame(3, 1'b1, 1'b0);
    queue_frame(12, 1'b1, 1'b1);
    queue_op(OP_READ, 10'd0);
    queue_op(OP_READ, 10'd7);
    run_phase();

    for (int ph = 0; ph < 4; ph++) begin
      set_limit(limits[ph]);
      if (ph == 3) quiet_tail = 1'b0;
      while (pending_items.size() < 140) begin
        r = $urandom_range(0, 99);
        if (r < 55) queue_frame($urandom_range(0, 30), $urandom_range(0, 9) == 0, 1'b0);
        else if (r < 65) queue_frame($urandom_range(8, 40), 1'b1, 1'b1);
        else if (r < 70) queue_frame($urandom_range(0, 100), 1'b0, 1'b0);
        else if (r < 78) queue_op(OP_READ, 10'($urandom_range(0, written_max - 1)));
        else if (r < 82) queue_op(OP_EOS, 10'd0);
        else if (r < 85) queue_op(OP_SPARE, 10'($urandom));
        else begin
          for (int k = $urandom_range(1, 6); k > 0; k--)
            pending_items = {pending_items, push_of(8'($urandom))};
        end
      end
      queue_op(OP_EOS, 10'd0);
      if (ph == 3) quiet_tail = 1'b1;
      run_phase();
    end

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
